// ===== rtl/core/sparse_kernel_evaluator_defines.svh =====
// Assertion helpers used by the top-level RTL file, sparse_kernel_evaluator.sv.
`ifndef SPARSE_KERNEL_EVALUATOR_DEFINES_SVH
`define SPARSE_KERNEL_EVALUATOR_DEFINES_SVH

`define SKE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define SKE_ASSERT_NEXT(label, cond, expect_q, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expect_q)) \
      else $error(msg);

`endif

// ===== rtl/core/ske_pkg.sv =====
package ske_pkg;

   localparam int MAX_FEATURES = 1024;
   localparam int ADDR_W = $clog2(MAX_FEATURES);
   localparam int CNT_W = ADDR_W + 1;

   localparam logic [1:0] KER_LIN  = 2'd0;
   localparam logic [1:0] KER_RBF  = 2'd1;
   localparam logic [1:0] KER_POLY = 2'd2;

   localparam logic [1:0] CSR_MODE = 2'd0;
   localparam logic [1:0] CSR_BW   = 2'd1;
   localparam logic [1:0] CSR_DEG  = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [21:0] EXP_LIMIT = 22'd2097152;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_ONE = 32'sd65536;

   typedef logic [16:0][31:0] exp_tab_type;

   typedef struct packed {
      logic start;
      logic ack;
      logic [1:0] mode;
      logic [31:0] bandwidth;
      logic [3:0] degree;
      logic signed [63:0] acc;
      logic [31:0] support_norm;
      logic [31:0] query_norm;
   } ker_cmd_type;

   typedef struct packed {
      logic valid;
      logic signed [31:0] kernel_value;
      logic signed [31:0] dot_product;
      logic saturated;
   } ker_res_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] r;
      logic [63:0] bv;
      rem = v;
      r = 64'd0;
      bv = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (rem >= r + bv) begin
            rem = rem - (r + bv);
            r = (r >> 1) + bv;
         end else begin
            r = r >> 1;
         end
         bv = bv >> 2;
      end
      return r;
   endfunction

   // Factors 2^(2^-i) in Q30, built by repeated square roots starting at 2.0.
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type t;
      logic [63:0] p;
      p = 64'h8000_0000;
      t[0] = 32'h8000_0000;
      for (int i = 1; i <= 16; i++) begin
         p = isqrt64(p << 30);
         t[i] = p[31:0];
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/core/ske_req_if.sv =====
interface ske_req_if;
   logic valid;
   logic ready;
   logic command;
   logic element_present;
   logic [31:0] feature_index;
   logic signed [31:0] feature_value;
   logic [31:0] squared_norm;
   logic last;

   modport source (output valid, command, element_present, feature_index, feature_value,
                   squared_norm, last, input ready);
   modport sink (input valid, command, element_present, feature_index, feature_value,
                 squared_norm, last, output ready);
endinterface

// ===== rtl/core/ske_rsp_if.sv =====
interface ske_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] kernel_value;
   logic signed [31:0] dot_product;
   logic saturated;

   modport source (output valid, kernel_value, dot_product, saturated, input ready);
   modport sink (input valid, kernel_value, dot_product, saturated, output ready);
endinterface

// ===== rtl/core/sparse_kernel_evaluator.sv =====
// Load words are written to the store from the idle state. A query word passes through the
// read and compare states, stepping the merge pointer past lower stored indices; a match adds
// an accumulate state. The last query word then runs the kernel: linear clips the dot product,
// polynomial multiplies and range-checks per degree, radial basis multiplies by the table factors.
// Reset is synchronous and active high; it empties the store and restores register defaults.
`include "sparse_kernel_evaluator_defines.svh"
module sparse_kernel_evaluator import ske_pkg::*; (
   input logic clock,
   input logic reset,
   ske_req_if.sink req,
   ske_rsp_if.source rsp,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [31:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CMP, S_ACC, S_KSTART, S_KWAIT
   } state_type;

   state_type state_ff;
   logic [1:0] mode_ff;
   logic [31:0] bw_ff;
   logic [3:0] deg_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0] snorm_ff;
   logic [CNT_W-1:0] ptr_ff;
   logic signed [63:0] acc_ff;
   logic load_open_ff;
   logic [31:0] qidx_ff;
   logic signed [31:0] qval_ff;
   logic [31:0] qnorm_ff;
   logic qlast_ff;
   logic signed [63:0] prod_ff;
   logic rsp_valid_ff;
   logic signed [31:0] rsp_kern_ff;
   logic signed [31:0] rsp_dot_ff;
   logic rsp_sat_ff;

   logic accept;
   logic [CNT_W-1:0] base_cnt;
   logic wr_en;
   logic rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [63:0] rd_data;
   logic [31:0] sidx;
   logic signed [31:0] sval;
   logic [CNT_W-1:0] ptr_nxt;
   logic signed [63:0] prod_in;
   logic xfer;
   state_type end_state;
   ker_cmd_type kcmd;
   ker_res_type kres;

   assign accept = req.valid & req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign base_cnt = load_open_ff ? count_ff : '0;
   assign wr_en = accept && (req.command == CMD_LOAD) && req.element_present
                  && (base_cnt < CNT_W'(MAX_FEATURES));
   assign sidx = rd_data[63:32];
   assign sval = rd_data[31:0];
   assign ptr_nxt = ptr_ff + 1'b1;
   assign prod_in = qval_ff * sval;
   assign end_state = qlast_ff ? S_KSTART : S_IDLE;
   assign xfer = (state_ff == S_KWAIT) && kres.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      rd_en = 1'b0;
      rd_addr = ptr_ff[ADDR_W-1:0];
      if (state_ff == S_READ) begin
         rd_en = ptr_ff < count_ff;
      end else if (state_ff == S_CMP && sidx < qidx_ff) begin
         rd_en = ptr_nxt < count_ff;
         rd_addr = ptr_nxt[ADDR_W-1:0];
      end
   end

   ske_store u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(base_cnt[ADDR_W-1:0]),
      .wr_data({req.feature_index, req.feature_value}),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign kcmd.start = (state_ff == S_KSTART);
   assign kcmd.ack = xfer;
   assign kcmd.mode = mode_ff;
   assign kcmd.bandwidth = bw_ff;
   assign kcmd.degree = deg_ff;
   assign kcmd.acc = acc_ff;
   assign kcmd.support_norm = snorm_ff;
   assign kcmd.query_norm = qnorm_ff;

   ske_kernel u_kernel (
      .clock(clock),
      .reset(reset),
      .cmd(kcmd),
      .res(kres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= KER_LIN;
         bw_ff <= 32'd65536;
         deg_ff <= 4'd2;
         count_ff <= '0;
         snorm_ff <= '0;
         ptr_ff <= '0;
         acc_ff <= '0;
         load_open_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE: mode_ff <= csr_wdata[1:0];
               CSR_BW: bw_ff <= csr_wdata;
               CSR_DEG: deg_ff <= csr_wdata[3:0];
               default: begin
               end
            endcase
         end
         if (xfer) begin
            rsp_valid_ff <= 1'b1;
            rsp_kern_ff <= kres.kernel_value;
            rsp_dot_ff <= kres.dot_product;
            rsp_sat_ff <= kres.saturated;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  qidx_ff <= req.feature_index;
                  qval_ff <= req.feature_value;
                  qnorm_ff <= req.squared_norm;
                  qlast_ff <= req.last;
                  if (req.command == CMD_LOAD) begin
                     ptr_ff <= '0;
                     acc_ff <= '0;
                     count_ff <= base_cnt + CNT_W'(wr_en);
                     load_open_ff <= !req.last;
                     if (req.last) begin
                        snorm_ff <= req.squared_norm;
                     end
                  end else if (req.element_present) begin
                     state_ff <= S_READ;
                  end else if (req.last) begin
                     state_ff <= S_KSTART;
                  end
               end
            end
            S_READ: begin
               state_ff <= (ptr_ff < count_ff) ? S_CMP : end_state;
            end
            S_CMP: begin
               if (sidx < qidx_ff) begin
                  ptr_ff <= ptr_nxt;
                  if (!(ptr_nxt < count_ff)) begin
                     state_ff <= end_state;
                  end
               end else if (sidx == qidx_ff) begin
                  prod_ff <= prod_in;
                  ptr_ff <= ptr_nxt;
                  state_ff <= S_ACC;
               end else begin
                  state_ff <= end_state;
               end
            end
            S_ACC: begin
               acc_ff <= acc_ff + (prod_ff >>> 16);
               state_ff <= end_state;
            end
            S_KSTART: begin
               state_ff <= S_KWAIT;
            end
            S_KWAIT: begin
               if (xfer) begin
                  ptr_ff <= '0;
                  acc_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.kernel_value = rsp_kern_ff;
   assign rsp.dot_product = rsp_dot_ff;
   assign rsp.saturated = rsp_sat_ff;

   `SKE_ASSERT(a_ptr_in_store, ptr_ff <= count_ff, "Merge pointer ran past the stored count.")
   `SKE_ASSERT(a_rsp_from_kernel, $rose(rsp_valid_ff) |-> $past(state_ff == S_KWAIT), "Response word appeared without a kernel result.")
   `SKE_ASSERT(a_kernel_waited, kres.valid |-> (state_ff == S_KWAIT), "Kernel result is ready outside the wait state.")
   `SKE_ASSERT_NEXT(a_load_clears, accept && (req.command == CMD_LOAD), (ptr_ff == '0) && (acc_ff == '0), "A load word did not clear the merge state.")

endmodule

// ===== rtl/core/ske_store.sv =====
module ske_store import ske_pkg::*; (
   input logic clock,
   input logic wr_en,
   input logic [ADDR_W-1:0] wr_addr,
   input logic [63:0] wr_data,
   input logic rd_en,
   input logic [ADDR_W-1:0] rd_addr,
   output logic [63:0] rd_data
);

   logic [63:0] mem_ff [MAX_FEATURES];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ske_kernel.sv =====
module ske_kernel import ske_pkg::*; (
   input logic clock,
   input logic reset,
   input ker_cmd_type cmd,
   output ker_res_type res
);

   typedef enum logic [3:0] {
      K_IDLE, K_MUL_LO, K_MUL_HI, K_XP, K_TMUL, K_FMUL, K_SCALE, K_PMUL, K_PCHK, K_DONE
   } kstate_type;

   kstate_type state_ff;
   logic neg_d_ff;
   logic [49:0] mag_ff;
   logic [31:0] bw_ff;
   logic [56:0] plo_ff;
   logic [56:0] phi_ff;
   logic signed [22:0] e_ff;
   logic signed [40:0] tprod_ff;
   logic [31:0] m_ff;
   logic [4:0] step_ff;
   logic signed [31:0] r_ff;
   logic signed [31:0] base_ff;
   logic signed [63:0] pprod_ff;
   logic [3:0] cnt_ff;
   logic neg_ff;
   logic signed [31:0] kern_ff;
   logic signed [31:0] dot_ff;
   logic sat_ff;

   logic signed [63:0] acc;
   logic dot_hi, dot_lo;
   logic signed [31:0] dotc;
   logic signed [48:0] accc;
   logic signed [50:0] d;
   logic [49:0] mag;
   logic signed [64:0] base;
   logic base_out;
   logic [56:0] plo_in, phi_in;
   logic [81:0] p_full;
   logic big;
   logic [21:0] x;
   logic signed [22:0] e_in;
   logic signed [40:0] tprod_in;
   logic [63:0] mmul;
   logic [5:0] fr_sel;
   logic signed [8:0] ip;
   logic signed [9:0] s;
   logic [9:0] sh;
   logic [32:0] v33;
   logic [63:0] rnd;
   logic exp_sat;
   logic signed [31:0] exp_val;
   logic signed [63:0] pprod_in;
   logic signed [63:0] rn;
   logic rn_out;

   always_comb begin
      acc = cmd.acc;
      dot_hi = acc > 64'sd2147483647;
      dot_lo = acc < -64'sd2147483648;
      dotc = dot_hi ? Q_MAX : (dot_lo ? Q_MIN : acc[31:0]);
      if (acc > 64'sd140737488355328) begin
         accc = 49'sd140737488355328;
      end else if (acc < -64'sd140737488355328) begin
         accc = -49'sd140737488355328;
      end else begin
         accc = acc[48:0];
      end
      d = $signed({19'b0, cmd.support_norm}) + $signed({19'b0, cmd.query_norm})
          - ($signed({{2{accc[48]}}, accc}) <<< 1);
      mag = d[50] ? 50'(-d) : d[49:0];
      base = 65'sd65536 + $signed({acc[63], acc});
      base_out = (base > 65'sd2147483647) || (base < -65'sd2147483648);

      plo_in = mag_ff[24:0] * bw_ff;
      phi_in = mag_ff[49:25] * bw_ff;
      p_full = {phi_ff, 25'b0} + {25'b0, plo_ff};
      big = p_full[81:16] > 66'(EXP_LIMIT);
      x = p_full[37:16];
      e_in = neg_d_ff ? $signed({1'b0, x}) : -$signed({1'b0, x});
      tprod_in = e_ff * $signed({1'b0, LOG2E_Q16});

      mmul = m_ff * EXP_TAB[step_ff];
      fr_sel = 6'd32 - {1'b0, step_ff};
      ip = tprod_ff[40:32];
      s = {ip[8], ip} - 10'sd14;
      sh = 10'(-s);
      v33 = (s == 10'sd1) ? {m_ff, 1'b0} : {1'b0, m_ff};
      rnd = ({32'b0, m_ff} + (64'd1 << (sh - 10'd1))) >> sh;
      exp_sat = 1'b0;
      if (!s[9]) begin
         if (s > 10'sd1 || v33 > 33'h0_7FFF_FFFF) begin
            exp_sat = 1'b1;
            exp_val = Q_MAX;
         end else begin
            exp_val = v33[31:0];
         end
      end else begin
         exp_val = rnd[31:0];
      end

      pprod_in = r_ff * base_ff;
      rn = pprod_ff >>> 16;
      rn_out = (rn > 64'sd2147483647) || (rn < -64'sd2147483648);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= K_IDLE;
      end else begin
         case (state_ff)
            K_IDLE: begin
               if (cmd.start) begin
                  dot_ff <= dotc;
                  sat_ff <= dot_hi | dot_lo;
                  case (cmd.mode)
                     KER_LIN: begin
                        kern_ff <= dotc;
                        state_ff <= K_DONE;
                     end
                     KER_RBF: begin
                        mag_ff <= mag;
                        neg_d_ff <= d[50];
                        bw_ff <= cmd.bandwidth;
                        state_ff <= K_MUL_LO;
                     end
                     KER_POLY: begin
                        if (cmd.degree == 4'd0) begin
                           kern_ff <= Q_ONE;
                           state_ff <= K_DONE;
                        end else if (base_out) begin
                           sat_ff <= 1'b1;
                           kern_ff <= (base[64] && cmd.degree[0]) ? Q_MIN : Q_MAX;
                           state_ff <= K_DONE;
                        end else begin
                           r_ff <= Q_ONE;
                           base_ff <= base[31:0];
                           cnt_ff <= cmd.degree;
                           neg_ff <= base[64] & cmd.degree[0];
                           state_ff <= K_PMUL;
                        end
                     end
                     default: begin
                        kern_ff <= '0;
                        state_ff <= K_DONE;
                     end
                  endcase
               end
            end
            K_MUL_LO: begin
               plo_ff <= plo_in;
               state_ff <= K_MUL_HI;
            end
            K_MUL_HI: begin
               phi_ff <= phi_in;
               state_ff <= K_XP;
            end
            K_XP: begin
               if (big) begin
                  if (neg_d_ff) begin
                     sat_ff <= 1'b1;
                     kern_ff <= Q_MAX;
                  end else begin
                     kern_ff <= '0;
                  end
                  state_ff <= K_DONE;
               end else begin
                  e_ff <= e_in;
                  state_ff <= K_TMUL;
               end
            end
            K_TMUL: begin
               tprod_ff <= tprod_in;
               m_ff <= 32'h4000_0000;
               step_ff <= 5'd1;
               state_ff <= K_FMUL;
            end
            K_FMUL: begin
               if (tprod_ff[fr_sel]) begin
                  m_ff <= mmul[61:30];
               end
               if (step_ff == 5'd16) begin
                  state_ff <= K_SCALE;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            K_SCALE: begin
               kern_ff <= exp_val;
               sat_ff <= sat_ff | exp_sat;
               state_ff <= K_DONE;
            end
            K_PMUL: begin
               pprod_ff <= pprod_in;
               state_ff <= K_PCHK;
            end
            K_PCHK: begin
               if (rn_out) begin
                  sat_ff <= 1'b1;
                  kern_ff <= neg_ff ? Q_MIN : Q_MAX;
                  state_ff <= K_DONE;
               end else if (cnt_ff == 4'd1) begin
                  kern_ff <= rn[31:0];
                  state_ff <= K_DONE;
               end else begin
                  r_ff <= rn[31:0];
                  cnt_ff <= cnt_ff - 4'd1;
                  state_ff <= K_PMUL;
               end
            end
            K_DONE: begin
               if (cmd.ack) begin
                  state_ff <= K_IDLE;
               end
            end
            default: begin
               state_ff <= K_IDLE;
            end
         endcase
      end
   end

   assign res.valid = (state_ff == K_DONE);
   assign res.kernel_value = kern_ff;
   assign res.dot_product = dot_ff;
   assign res.saturated = sat_ff;

endmodule

// ===== dv/ske_req_if.sv =====
`timescale 1ns / 100ps

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import ske_pkg::*;

   typedef struct {
      logic signed [31:0] kernel_value;
      logic signed [31:0] dot_product;
      logic saturated;
   } kernel_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [31:0] csr_wdata;

   ske_req_if req ();
   ske_rsp_if rsp ();

   sparse_kernel_evaluator DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [1:0] mode_q;
   logic [31:0] bandwidth_q;
   logic [3:0] degree_q;
   logic [31:0] sv_index [MAX_FEATURES];
   logic [31:0] sv_value [MAX_FEATURES];
   int unsigned sv_count;
   logic [31:0] sv_norm;
   int unsigned merge_ptr;
   longint dot_acc;
   bit load_active;

   kernel_result_type pending_results [$];
   int unsigned error_count;
   int unsigned result_count;
   logic [63:0] exp_factor [17];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("testbench failed");
      $finish;
   end

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip32(longint v, ref bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint exp_fixed(longint e, ref bit sat);
      logic [63:0] m;
      logic [63:0] v;
      longint t;
      longint ip;
      longint s;
      logic [15:0] fr;
      m = 64'd1 << 30;
      t = floor_shr(e * 94548, 16);
      ip = floor_shr(t, 16);
      fr = t[15:0];
      for (int i = 1; i <= 16; i++)
         if (fr[16 - i]) m = (m * exp_factor[i]) >> 30;
      s = ip - 14;
      if (s >= 0) begin
         if (s > 1) begin
            sat = 1'b1;
            return 64'sd2147483647;
         end
         v = m << s;
         if (v > 64'd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
         end
         return longint'(v);
      end
      if (-s >= 63) return 0;
      return longint'((m + (64'd1 << (-s - 1))) >> (-s));
   endfunction

   function automatic longint radial_kernel(logic [31:0] qnorm, ref bit sat);
      longint d;
      longint x;
      longint dv;
      logic [63:0] mag;
      logic [63:0] bw;
      dv = dot_acc;
      bw = bandwidth_q;
      if (dv > (64'sd1 <<< 47)) dv = 64'sd1 <<< 47;
      if (dv < -(64'sd1 <<< 47)) dv = -(64'sd1 <<< 47);
      d = longint'({32'd0, sv_norm}) + longint'({32'd0, qnorm}) - 2 * dv;
      mag = d < 0 ? -d : d;
      if (bw != 0 && mag > ((64'd33 << 32) / bw)) x = 64'sd2097153;
      else x = longint'((mag * bw) >> 16);
      if (d >= 0) begin
         if (x > 64'sd2097152) return 0;
         return exp_fixed(-x, sat);
      end
      if (x > 64'sd2097152) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      return exp_fixed(x, sat);
   endfunction

   function automatic longint poly_power(ref bit sat);
      longint base;
      longint r;
      bit neg;
      base = 65536 + dot_acc;
      r = 65536;
      neg = base < 0 && degree_q[0];
      if (degree_q == 0) return 65536;
      if (base > 64'sd2147483647 || base < -64'sd2147483648) begin
         sat = 1'b1;
         return neg ? -64'sd2147483648 : 64'sd2147483647;
      end
      for (int i = 0; i < degree_q; i++) begin
         r = floor_shr(r * base, 16);
         if (r > 64'sd2147483647 || r < -64'sd2147483648) begin
            sat = 1'b1;
            return neg ? -64'sd2147483648 : 64'sd2147483647;
         end
      end
      return r;
   endfunction

   function automatic void predict_word(logic cmd, logic present, logic [31:0] idx,
                                        logic signed [31:0] val, logic [31:0] norm,
                                        logic lst);
      kernel_result_type res;
      bit sat;
      longint dot;
      longint kern;
      sat = 1'b0;
      if (cmd == CMD_LOAD) begin
         merge_ptr = 0;
         dot_acc = 0;
         if (!load_active) sv_count = 0;
         if (present && sv_count < MAX_FEATURES) begin
            sv_index[sv_count] = idx;
            sv_value[sv_count] = val;
            sv_count++;
         end
         if (lst) begin
            sv_norm = norm;
            load_active = 1'b0;
         end else begin
            load_active = 1'b1;
         end
         return;
      end
      if (present) begin
         while (merge_ptr < sv_count && sv_index[merge_ptr] < idx) merge_ptr++;
         if (merge_ptr < sv_count && sv_index[merge_ptr] == idx) begin
            dot_acc += floor_shr(longint'(val) * longint'($signed(sv_value[merge_ptr])), 16);
            merge_ptr++;
         end
      end
      if (!lst) return;
      dot = clip32(dot_acc, sat);
      case (mode_q)
         KER_LIN: kern = dot;
         KER_RBF: kern = radial_kernel(norm, sat);
         KER_POLY: kern = poly_power(sat);
         default: kern = 0;
      endcase
      res.kernel_value = kern[31:0];
      res.dot_product = dot[31:0];
      res.saturated = sat;
      pending_results = {pending_results, res};
      merge_ptr = 0;
      dot_acc = 0;
   endfunction

   task automatic send_word(logic cmd, logic present, logic [31:0] idx,
                            logic signed [31:0] val, logic [31:0] norm, logic lst);
      if ($urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= cmd;
      req.element_present <= present;
      req.feature_index <= idx;
      req.feature_value <= val;
      req.squared_norm <= norm;
      req.last <= lst;
      do @(posedge clock); while (!req.ready);
      predict_word(cmd, present, idx, val, norm, lst);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      while (!req.ready) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MODE: mode_q = data[1:0];
         CSR_BW: bandwidth_q = data;
         default: degree_q = data[3:0];
      endcase
   endtask

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
         default: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      endcase
   endfunction

   task automatic send_vector(logic cmd, int n, logic [31:0] base, int step,
                              logic [31:0] norm);
      logic [31:0] idx;
      idx = base;
      if (n == 0) begin
         send_word(cmd, 1'b0, $urandom, rand_value(), norm, 1'b1);
         return;
      end
      for (int i = 0; i < n; i++) begin
         send_word(cmd, 1'b1, idx, rand_value(), norm, i == n - 1);
         idx = idx + $urandom_range(1, step);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         rsp.ready <= ($urandom_range(0, 9) < 7) || (result_count % 16 < 4);
         if (rsp.valid && rsp.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               $error("unexpected result");
               error_count++;
            end else begin
               kernel_result_type e;
               e = pending_results.pop_front();
               if (rsp.kernel_value !== e.kernel_value) begin
                  $error("kernel_value expected %h actual %h", e.kernel_value,
                         rsp.kernel_value);
                  error_count++;
               end
               if (rsp.dot_product !== e.dot_product) begin
                  $error("dot_product expected %h actual %h", e.dot_product,
                         rsp.dot_product);
                  error_count++;
               end
               if (rsp.saturated !== e.saturated) begin
                  $error("saturated expected %b actual %b", e.saturated, rsp.saturated);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic test_directed();
      send_word(CMD_QUERY, 1'b0, 0, 0, 0, 1'b1);
      send_word(CMD_LOAD, 1'b1, 32'd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_word(CMD_LOAD, 1'b1, 32'd5, 32'sh8000_0000, 0, 1'b0);
      send_word(CMD_LOAD, 1'b1, 32'hFFFF_FFFF, 32'sh0001_0000, 32'h0003_0000, 1'b1);
      send_word(CMD_QUERY, 1'b1, 32'd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_word(CMD_QUERY, 1'b1, 32'd5, 32'sh8000_0000, 0, 1'b0);
      send_word(CMD_QUERY, 1'b1, 32'hFFFF_FFFF, 32'sh0002_0000, 32'h0001_0000, 1'b1);
      send_word(CMD_QUERY, 1'b1, 32'd3, 32'sh0001_0000, 0, 1'b0);
      send_word(CMD_LOAD, 1'b1, 32'd2, 32'sh0002_0000, 0, 1'b0);
      send_word(CMD_QUERY, 1'b1, 32'd2, 32'sh0003_0000, 0, 1'b1);
      send_word(CMD_LOAD, 1'b0, 0, 0, 32'h0000_8000, 1'b1);
      send_word(CMD_QUERY, 1'b1, 32'd9, 32'sh0001_0000, 0, 1'b0);
      send_word(CMD_QUERY, 1'b1, 32'd4, 32'sh0001_0000, 0, 1'b1);
      send_word(CMD_LOAD, 1'b0, 0, 0, 32'h0001_0000, 1'b1);
      send_word(CMD_QUERY, 1'b0, 0, 0, 32'h0002_0000, 1'b1);
   endtask

   task automatic test_random(int words);
      int sent;
      int n;
      logic [31:0] base;
      logic [31:0] qnorm;
      sent = 0;
      while (sent < words) begin
         n = $urandom_range(0, 6);
         base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               send_vector(CMD_LOAD, n, base, 3, $urandom);
            end
            3: begin
               send_word(1'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                         1'($urandom));
               n = 1;
            end
            default: begin
               qnorm = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 1 << 19) : $urandom;
               send_vector(CMD_QUERY, n, base, 3, qnorm);
            end
         endcase
         sent += (n == 0) ? 1 : n;
      end
   endtask

   task automatic test_kernel_modes();
      write_csr(CSR_MODE, KER_RBF);
      write_csr(CSR_BW, 32'd0);
      test_random(40);
      write_csr(CSR_BW, 32'hFFFF_FFFF);
      test_random(40);
      write_csr(CSR_BW, $urandom_range(256, 1 << 17));
      test_random(80);
      write_csr(CSR_MODE, KER_POLY);
      write_csr(CSR_DEG, 4'd0);
      test_random(30);
      write_csr(CSR_DEG, 4'd15);
      test_random(30);
      write_csr(CSR_DEG, $urandom_range(1, 5));
      test_random(60);
      write_csr(CSR_MODE, 2'd3);
      test_random(30);
      write_csr(CSR_MODE, KER_LIN);
      test_random(60);
   endtask

   initial begin
      mode_q = KER_LIN;
      bandwidth_q = 32'd65536;
      degree_q = 4'd2;
      sv_count = 0;
      sv_norm = 0;
      merge_ptr = 0;
      dot_acc = 0;
      load_active = 1'b0;
      error_count = 0;
      result_count = 0;
      exp_factor[0] = 64'd1 << 31;
      for (int i = 1; i <= 16; i++) exp_factor[i] = root64(exp_factor[i - 1] << 30);
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = 0;
      csr_wdata = 0;
      req.valid = 1'b0;
      req.command = 1'b0;
      req.element_present = 1'b0;
      req.feature_index = 0;
      req.feature_value = 0;
      req.squared_norm = 0;
      req.last = 1'b0;
      rsp.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(60);
      test_kernel_modes();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
